// File: rtl/epf_pkg.sv
`default_nettype none
package epf_pkg;

  localparam int CNT_W  = 10;
  localparam int PER_W  = 30;
  localparam int DUTY_W = 29;

  localparam int DIV_STEPS = PER_W;

  localparam int unsigned TIME_BASE_DEF = 1000000000;

  localparam logic [CNT_W-1:0]  START_COUNT     = CNT_W'(10);
  localparam logic [CNT_W-1:0]  RESET_MAX_COUNT = CNT_W'(500);
  localparam logic [PER_W-1:0]  START_PERIOD    = PER_W'(100000000);

endpackage
`default_nettype wire

// File: rtl/epf_if.sv
`default_nettype none
interface epf_in_if;
  logic valid;
  logic ready;
  logic line_a;
  logic line_b;

  modport source (output valid, output line_a, output line_b, input ready);
  modport sink   (input valid, input line_a, input line_b, output ready);
endinterface

interface epf_out_if;
  logic                        valid;
  logic                        ready;
  logic [epf_pkg::CNT_W-1:0]   count;
  logic [epf_pkg::PER_W-1:0]   period_ns;
  logic [epf_pkg::DUTY_W-1:0]  duty_ns;
  logic                        updated;

  modport source (output valid, output count, output period_ns, output duty_ns,
                  output updated, input ready);
  modport sink   (input valid, input count, input period_ns, input duty_ns,
                  input updated, output ready);
endinterface

interface epf_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [epf_pkg::CNT_W-1:0] max_count;

  modport source (output valid, output max_count, input ready);
  modport sink   (input valid, input max_count, output ready);
endinterface
`default_nettype wire

// File: rtl/epf_divider.sv
`default_nettype none
module epf_divider #(
  parameter int unsigned TIME_BASE = epf_pkg::TIME_BASE_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [epf_pkg::CNT_W-1:0] divisor,
  output logic                           done,
  output logic [epf_pkg::PER_W-1:0]      quotient
);
  import epf_pkg::*;

  localparam int STEP_W = $clog2(DIV_STEPS);
  localparam logic [PER_W-1:0] DIVIDEND = PER_W'(TIME_BASE);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dvs;
  logic [PER_W-1:0]  quo;

  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              fits;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem, quo[PER_W-1]};
    diff  = trial - {1'b0, dvs};
    fits  = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(DIV_STEPS - 1);
        rem  <= '0;
        dvs  <= divisor;
        quo  <= DIVIDEND;
      end else if (busy) begin
        rem <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        quo <= {quo[PER_W-2:0], fits};
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule
`default_nettype wire

// File: rtl/encoder_to_pwm_frequency_unit.sv
`default_nettype none
// channel  dir  payload                              handshake
// enc      in   line_a, line_b                       valid/ready
// res      out  count, period_ns, duty_ns, updated   valid/ready
// cfg      in   max_count                            valid/ready, always ready
//
// A word that reloads a nonzero count is accepted, runs through the bit-serial
// divider (30 quotient bits, then done) and then loads the output. Other words
// skip the divider. The next word is accepted while a result waits.
// Synchronous reset restores count 10, period 100000000, max_count 500.
// A stalled result holds only the output register; enc stalls once a second
// result is ready behind it.
module encoder_to_pwm_frequency_unit #(
  parameter int unsigned TIME_BASE = epf_pkg::TIME_BASE_DEF
) (
  input wire logic clk,
  input wire logic rst,
  epf_in_if.sink   enc,
  epf_out_if.source res,
  epf_cfg_if.sink  cfg
);
  import epf_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_PUSH} state_t;

  state_t            state;
  logic [CNT_W-1:0]  max_count;
  logic              prev_a;
  logic              primed;
  logic [CNT_W-1:0]  enc_count;
  logic [CNT_W-1:0]  last_applied;
  logic [PER_W-1:0]  period_reg;
  logic [DUTY_W-1:0] duty_reg;
  logic              upd;

  logic [CNT_W:0]    step_n;
  logic [CNT_W-1:0]  clamped;
  logic              changed;
  logic              div_start;
  logic              div_done;
  logic [PER_W-1:0]  div_quo;

  always_comb begin
    step_n = {1'b0, enc_count};
    if (enc.line_a && !prev_a) begin
      if (enc.line_b != enc.line_a) begin
        step_n = {1'b0, enc_count} + 1'b1;
      end else if (enc_count != '0) begin
        step_n = {1'b0, enc_count} - 1'b1;
      end
    end
    changed = step_n != {1'b0, last_applied};
    clamped = (step_n > {1'b0, max_count}) ? max_count : step_n[CNT_W-1:0];
  end

  assign enc.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign div_start = (state == S_IDLE) && enc.valid && primed && changed && (clamped != '0);

  epf_divider #(.TIME_BASE(TIME_BASE)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (clamped),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      max_count    <= RESET_MAX_COUNT;
      prev_a       <= 1'b0;
      primed       <= 1'b0;
      enc_count    <= START_COUNT;
      last_applied <= '0;
      period_reg   <= START_PERIOD;
      duty_reg     <= '0;
      upd          <= 1'b0;
      res.valid    <= 1'b0;
    end else begin
      if (cfg.valid) begin
        max_count <= cfg.max_count;
      end
      if (res.valid && res.ready && state != S_PUSH) begin
        res.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (enc.valid) begin
            prev_a <= enc.line_a;
            primed <= 1'b1;
            upd    <= primed && changed;
            state  <= div_start ? S_DIV : S_PUSH;
            if (primed) begin
              if (changed) begin
                enc_count    <= clamped;
                last_applied <= clamped;
                if (clamped == '0) begin
                  duty_reg <= '0;
                end
              end else begin
                enc_count <= step_n[CNT_W-1:0];
              end
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            period_reg <= div_quo;
            duty_reg   <= DUTY_W'(div_quo >> 1);
            state      <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!res.valid || res.ready) begin
            res.valid     <= 1'b1;
            res.count     <= enc_count;
            res.period_ns <= period_reg;
            res.duty_ns   <= duty_reg;
            res.updated   <= upd;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside division state");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> enc_count != '0 && upd)
    else $error("division running for a zero count");

  a_zero_off: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH && upd && enc_count == '0) |-> duty_reg == '0)
    else $error("zero count left duty on");

  a_applied: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH && upd) |-> last_applied == enc_count)
    else $error("reload without matching applied count");

endmodule
`default_nettype wire
